// File: design/mse_pkg.sv
package mse_pkg;

    // Element width and default set capacity
    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [DATA_W-1:0] t_value;

    // Per-cycle commands from the sequencer to the storage and output stage
    typedef struct packed {
        logic load;       // write the incoming item into store A
        logic wr_a;       // write store A with the merge winner
        logic wr_b;       // write store B with the merge winner
        logic take_left;  // merge winner comes from the left run
        logic src_b;      // sorted data currently lives in store B
        logic out_load;   // capture the read data into the output register
        logic out_final;  // captured item is the last of the set
    } t_ctl;

endpackage

// File: design/mse_if.sv
// Input channel: one element per item
interface mse_in_if import mse_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

// Output channel: one sorted element per item
interface mse_out_if import mse_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   final_res;

    modport source (output valid, output sorted_value, output final_res, input ready);
    modport sink   (input valid, input sorted_value, input final_res, output ready);
endinterface

// File: design/mse_ram.sv
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one port, read two with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// File: design/mse_ctrl.sv
module mse_ctrl import mse_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_last,
    output logic                        o_in_ready,
    input  logic                        i_out_free,
    input  t_value                      i_rd_l,
    input  t_value                      i_rd_r,
    output t_ctl                        o_ctl,
    output logic [$clog2(CAPACITY)-1:0] o_waddr,
    output logic [$clog2(CAPACITY)-1:0] o_raddr_l,
    output logic [$clog2(CAPACITY)-1:0] o_raddr_r
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_PAIR = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_ERD  = 3'd4;
    localparam logic [2:0] S_EOUT = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic          r_src_b, n_src_b;
    logic [EW-1:0] r_w,   n_w;
    logic [EW-1:0] r_lo,  n_lo;
    logic [EW-1:0] r_mid, n_mid;
    logic [EW-1:0] r_hi,  n_hi;
    logic [EW-1:0] r_l,   n_l;
    logic [EW-1:0] r_r,   n_r;
    logic [EW-1:0] r_k,   n_k;

    logic [EW-1:0] num;
    logic [CW-1:0] cnt_after;
    logic [EW-1:0] w2;
    logic [EW-1:0] sum_mid;
    logic [EW-1:0] sum_hi;
    logic          l_ok;
    logic          r_ok;
    logic          take_left;

    assign num       = EW'(r_cnt);
    assign cnt_after = (r_cnt < CAP_C) ? r_cnt + CW'(1) : r_cnt;
    assign w2        = r_w << 1;
    assign sum_mid   = r_lo + r_w;
    assign sum_hi    = r_lo + w2;
    assign l_ok      = r_l < r_mid;
    assign r_ok      = r_r < r_hi;
    // Shared compare unit: left wins on equal values
    assign take_left = l_ok && (!r_ok || (i_rd_l <= i_rd_r));

    // Sequence load, merge passes and emission
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_src_b   = r_src_b;
        n_w       = r_w;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_l       = r_l;
        n_r       = r_r;
        n_k       = r_k;
        o_ctl     = '0;
        o_ctl.src_b = r_src_b;
        o_in_ready  = 1'b0;
        o_waddr   = r_k[AW-1:0];
        o_raddr_l = r_l[AW-1:0];
        o_raddr_r = r_r[AW-1:0];

        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_waddr    = r_cnt[AW-1:0];
                if (i_in_valid) begin
                    // drop the item once the store is full
                    o_ctl.load = r_cnt < CAP_C;
                    o_ctl.wr_a = r_cnt < CAP_C;
                    n_cnt      = cnt_after;
                    if (i_in_last) begin
                        n_src_b = 1'b0;
                        n_lo    = '0;
                        n_w     = EW'(1);
                        n_k     = '0;
                        n_state = (cnt_after == CW'(1)) ? S_ERD : S_PAIR;
                    end
                end
            end
            S_PAIR: begin
                if (r_lo >= num) begin
                    // pass done: swap stores, double the run width
                    n_src_b = !r_src_b;
                    n_lo    = '0;
                    n_w     = w2;
                    n_k     = '0;
                    if (w2 >= num) begin
                        n_state = S_ERD;
                    end
                end else begin
                    n_mid   = (sum_mid > num) ? num : sum_mid;
                    n_hi    = (sum_hi > num) ? num : sum_hi;
                    n_l     = r_lo;
                    n_r     = (sum_mid > num) ? num : sum_mid;
                    n_k     = r_lo;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_ctl.wr_a      = r_src_b;
                o_ctl.wr_b      = !r_src_b;
                o_ctl.take_left = take_left;
                if (take_left) begin
                    n_l = r_l + EW'(1);
                end else begin
                    n_r = r_r + EW'(1);
                end
                n_k = r_k + EW'(1);
                if (r_k + EW'(1) == r_hi) begin
                    n_lo    = r_hi;
                    n_state = S_PAIR;
                end else begin
                    n_state = S_RD;
                end
            end
            S_ERD: begin
                o_raddr_l = r_k[AW-1:0];
                n_state   = S_EOUT;
            end
            S_EOUT: begin
                o_raddr_l = r_k[AW-1:0];
                if (i_out_free) begin
                    o_ctl.out_load  = 1'b1;
                    o_ctl.out_final = (r_k + EW'(1) == num);
                    n_k = r_k + EW'(1);
                    if (r_k + EW'(1) == num) begin
                        n_cnt   = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Hold control state; indices need no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_src_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_src_b <= n_src_b;
        end
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_l   <= n_l;
        r_r   <= n_r;
        r_k   <= n_k;
    end

endmodule

// File: design/merge_sort_engine.sv
// Merge sort engine for sets of signed 32-bit values.
// Input channel i_in: one element per item, the final element of a set
// carries last. Elements beyond CAPACITY are dropped; a dropped item
// marked last still closes the set.
// Output channel o_out: the set in ascending order, one element per item,
// final_res set on the last one. Equal values keep their arrival order.
// Loading accepts one item per cycle. After the item marked last the block
// runs ceil(log2 n) bottom-up merge passes over two ping-pong stores; the
// shared compare unit steps through a read state (S_RD) for the registered
// RAM read and a compare state (S_CMP) for each element that it writes.
// Emission then steps each element through S_ERD and S_EOUT, waiting in
// S_EOUT while the output register is full.
// i_in.ready is high only while a set is loading. A stalled receiver holds
// the output register and the emission waits; the next set can load while
// the final result still waits to be taken.
// Reset (i_rst_n low, synchronous) empties the set and the output register.
module merge_sort_engine import mse_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mse_in_if.sink     i_in,
    mse_out_if.source  o_out
);

    localparam int AW = $clog2(CAPACITY);

    t_ctl          ctl;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_l;
    logic [AW-1:0] raddr_r;
    t_value        a_rd0, a_rd1, b_rd0, b_rd1;
    t_value        rd_l, rd_r;
    t_value        winner;
    t_value        a_wdata;
    logic          out_free;

    logic          r_out_valid;
    t_value        r_out_value;
    logic          r_out_final;

    assign rd_l     = ctl.src_b ? b_rd0 : a_rd0;
    assign rd_r     = ctl.src_b ? b_rd1 : a_rd1;
    assign winner   = ctl.take_left ? rd_l : rd_r;
    assign a_wdata  = ctl.load ? i_in.value : winner;
    assign out_free = !r_out_valid || o_out.ready;

    mse_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_out_free (out_free),
        .i_rd_l     (rd_l),
        .i_rd_r     (rd_r),
        .o_ctl      (ctl),
        .o_waddr    (waddr),
        .o_raddr_l  (raddr_l),
        .o_raddr_r  (raddr_r)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store_a (
        .i_clk    (i_clk),
        .i_we     (ctl.wr_a),
        .i_waddr  (waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (raddr_l),
        .i_raddr1 (raddr_r),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    mse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_store_b (
        .i_clk    (i_clk),
        .i_we     (ctl.wr_b),
        .i_waddr  (waddr),
        .i_wdata  (winner),
        .i_raddr0 (raddr_l),
        .i_raddr1 (raddr_r),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    // Hold the result until taken, load the next when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (ctl.out_load) begin
            r_out_value <= rd_l;
            r_out_final <= ctl.out_final;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.final_res    = r_out_final;

endmodule

// File: design/mse_chk.sv
module mse_chk import mse_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_in_last,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_value i_out_value,
    input logic   i_out_final
);

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_final))
        else $error("stalled result changed");

    // Closing a set starts the sort, so loading stops
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input still ready after the last item");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A new result is only produced while no set is loading
    a_emit_not_loading: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while loading");

endmodule

bind merge_sort_engine mse_chk u_mse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_value (o_out.sorted_value),
    .i_out_final (o_out.final_res)
);

// File: dv/tb_merge_sort_engine.sv
module tb_merge_sort_engine;
    import mse_pkg::*;

    localparam int HOLD_CYCLES  = 1500;
    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = 400;
    localparam int TARGET_ITEMS = 480;

    typedef struct {
        t_value value;
        logic   is_end;
    } t_sorted_item;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mse_in_if  in_ch ();
    mse_out_if out_ch ();

    merge_sort_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: elements held for the open set, sorted items owed by the block
    t_value       set_held[$];
    t_sorted_item sorted_owed[$];

    int errors     = 0;
    int items_sent = 0;
    int idle_count = 0;
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_req    = 1'b0;

    // Store the element if there is room; on last, sort the set stably and owe it
    function automatic void predict_element(input t_value v, input logic is_last);
        t_value       ordered[$];
        t_value       key;
        t_sorted_item entry;
        int           j;
        if (set_held.size() < CAPACITY_DEF)
            set_held.push_back(v);
        if (!is_last)
            return;
        ordered = set_held;
        for (int i = 1; i < ordered.size(); i++) begin
            key = ordered[i];
            j   = i - 1;
            // strict compare keeps equal values in arrival order
            while (j >= 0 && ordered[j] > key) begin
                ordered[j+1] = ordered[j];
                j--;
            end
            ordered[j+1] = key;
        end
        foreach (ordered[k]) begin
            entry.value  = ordered[k];
            entry.is_end = (k == ordered.size() - 1);
            sorted_owed.push_back(entry);
        end
        set_held.delete();
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_value random_value(input int mode);
        case (mode)
            0: return t_value'($urandom);
            1: return t_value'($urandom_range(0, 8)) - 4;
            default: begin
                case ($urandom_range(0, 4))
                    0: return {1'b1, {(DATA_W-1){1'b0}}};
                    1: return {1'b0, {(DATA_W-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return t_value'($urandom);
                endcase
            end
        endcase
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_element(input t_value v, input logic is_last);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= is_last;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_element(v, is_last);
        items_sent++;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_set(input t_value vals[$]);
        foreach (vals[k])
            send_element(vals[k], k == vals.size() - 1);
    endtask

    task automatic send_random_set(input int len, input int mode);
        t_value vals[$];
        repeat (len) vals.push_back(random_value(mode));
        send_set(vals);
    endtask

    task automatic wait_drained();
        while (sorted_owed.size() != 0) @(posedge i_clk);
    endtask

    // Extremes, single elements, duplicates and reversed order
    task automatic test_directed();
        t_value vmin;
        t_value vmax;
        vmin = {1'b1, {(DATA_W-1){1'b0}}};
        vmax = {1'b0, {(DATA_W-1){1'b1}}};
        send_set('{vmin});
        send_set('{vmax});
        send_set('{vmax, vmin});
        send_set('{t_value'(5), t_value'(5), t_value'(5)});
        send_set('{t_value'(0), t_value'(-1), t_value'(1), vmin, vmax,
                   vmin + 1, vmax - 1});
        send_set('{t_value'(7), t_value'(6), t_value'(5), t_value'(4),
                   t_value'(3), t_value'(2), t_value'(1), t_value'(0),
                   t_value'(-1)});
    endtask

    // Fill exactly to capacity, then overrun it so the item marked last is dropped
    task automatic test_overflow();
        send_random_set(CAPACITY_DEF, 0);
        send_random_set(CAPACITY_DEF + 2, 2);
    endtask

    // Hold the receiver off while sets keep coming, so the input stalls
    task automatic test_receiver_hold();
        hold_req = 1'b1;
        repeat (3) send_random_set($urandom_range(4, 12), 0);
    endtask

    // Pause the sender until every owed result is out, then carry on
    task automatic test_drain_pause();
        send_random_set($urandom_range(2, 10), 1);
        in_ch.valid <= 1'b0;
        wait_drained();
        send_random_set($urandom_range(2, 10), 0);
    endtask

    // Random sets, mostly small, a few up to capacity
    task automatic test_random_sets();
        int r;
        int len;
        while (items_sent < TARGET_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                len = $urandom_range(1, 12);
            else if (r < 92)
                len = $urandom_range(13, 40);
            else
                len = $urandom_range(41, CAPACITY_DEF);
            src_steady = ($urandom_range(0, 99) < 15);
            send_random_set(len, $urandom_range(0, 2));
        end
        src_steady = 1'b0;
    endtask

    // Receiver: random stalls, stretches without stalls, one long hold when asked
    initial begin
        int gap;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                gap = pick_gap(sink_steady);
                if (gap == 0) begin
                    out_ch.ready <= 1'b1;
                end else begin
                    out_ch.ready <= 1'b0;
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
        end
    end

    // Compare each sorted item with the oldest owed one
    always @(posedge i_clk) begin
        t_sorted_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (sorted_owed.size() == 0) begin
                $error("unexpected sorted item: sorted_value %0d final_res %0b",
                       out_ch.sorted_value, out_ch.final_res);
                errors++;
            end else begin
                want = sorted_owed.pop_front();
                if (out_ch.sorted_value !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           want.value, out_ch.sorted_value);
                    errors++;
                end
                if (out_ch.final_res !== want.is_end) begin
                    $error("final_res: expected %0b, got %0b",
                           want.is_end, out_ch.final_res);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count == IDLE_LIMIT) begin
            $display("FAIL merge_sort_engine");
            $finish;
        end
    end

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        in_ch.last  <= 1'b0;
        i_rst_n     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_overflow();
        test_receiver_hold();
        sink_steady = 1'b1;
        test_random_sets();

        in_ch.valid <= 1'b0;
        sink_steady = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sorted_owed.size() != 0) begin
            $error("%0d sorted items never arrived", sorted_owed.size());
            errors++;
        end
        if (errors == 0)
            $display("PASS merge_sort_engine");
        else
            $display("FAIL merge_sort_engine");
        $finish;
    end

    // Let the receiver stall again partway through the random sets
    initial begin
        wait (items_sent >= 300);
        sink_steady = 1'b0;
    end

endmodule

// File: merge_sort_engine.f
design/mse_pkg.sv
design/mse_if.sv
design/mse_ram.sv
design/mse_ctrl.sv
design/merge_sort_engine.sv
design/mse_chk.sv
dv/tb_merge_sort_engine.sv
